[rtl/dcic_pkg.sv]
`timescale 1ns / 1ps

package dcic_pkg;

	localparam int unsigned SECTOR_COUNT = 18;
	localparam int unsigned STRIPS_A     = 15;
	localparam int unsigned STRIPS_B     = 19;
	localparam int unsigned STRIPS_C     = 19;
	localparam int unsigned PADS_Z       = 2;
	localparam int unsigned PADS_X       = 48;

	localparam int unsigned PLATE_COUNT       = 5;
	localparam int unsigned STRIPS_PER_SECTOR = 2 * (STRIPS_C + STRIPS_B) + STRIPS_A;
	localparam int unsigned PADS_PER_STRIP    = PADS_Z * PADS_X;
	localparam int unsigned SECTOR_SIZE       = STRIPS_PER_SECTOR * PADS_PER_STRIP;

	localparam int unsigned CH_W     = 18;
	localparam int unsigned SECTOR_W = 5;
	localparam int unsigned PLATE_W  = 3;
	localparam int unsigned STRIP_W  = 5;
	localparam int unsigned PADZ_W   = 1;
	localparam int unsigned PADX_W   = 6;
	localparam int unsigned STATUS_W = 2;

	localparam int unsigned CH_LSB     = 0;
	localparam int unsigned SECTOR_LSB = CH_LSB + CH_W;
	localparam int unsigned PLATE_LSB  = SECTOR_LSB + SECTOR_W;
	localparam int unsigned STRIP_LSB  = PLATE_LSB + PLATE_W;
	localparam int unsigned PADZ_LSB   = STRIP_LSB + STRIP_W;
	localparam int unsigned PADX_LSB   = PADZ_LSB + PADZ_W;
	localparam int unsigned FIELDS_W   = PADX_LSB + PADX_W;
	localparam int unsigned DATA_W     = ((FIELDS_W + 7) / 8) * 8;

	// strip index within a sector and pad index within a strip
	localparam int unsigned SIDX_W   = $clog2(STRIPS_PER_SECTOR + 1);
	localparam int unsigned PAD_W    = $clog2(PADS_PER_STRIP + 1);
	localparam int unsigned STRIDX_W = ((SIDX_W > STRIP_W) ? SIDX_W : STRIP_W) + 1;
	localparam int unsigned PADIDX_W = PADX_W + 1;

	// reciprocals for constant division, estimate low by at most one
	localparam int unsigned RECIP_SHIFT = CH_W;
	localparam int unsigned RECIP_W     = CH_W + 1;
	localparam int unsigned MUL_W       = CH_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP_PPS = RECIP_W'((1 << RECIP_SHIFT) / PADS_PER_STRIP);
	localparam logic [RECIP_W-1:0] RECIP_SPS = RECIP_W'((1 << RECIP_SHIFT) / STRIPS_PER_SECTOR);
	localparam logic [RECIP_W-1:0] RECIP_PX  = RECIP_W'((1 << RECIP_SHIFT) / PADS_X);

	localparam int unsigned PIPE_DEPTH = 7;

	localparam logic [PLATE_W-1:0] PLATE_0 = 3'd0;
	localparam logic [PLATE_W-1:0] PLATE_1 = 3'd1;
	localparam logic [PLATE_W-1:0] PLATE_2 = 3'd2;
	localparam logic [PLATE_W-1:0] PLATE_3 = 3'd3;
	localparam logic [PLATE_W-1:0] PLATE_4 = 3'd4;

	typedef enum logic {
		CMD_ENCODE = 1'b0,
		CMD_DECODE = 1'b1
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK         = 2'd0,
		STATUS_BAD_SECTOR = 2'd1,
		STATUS_BAD_PLATE  = 2'd2,
		STATUS_BAD_STRIP  = 2'd3
	} status_t;

	typedef struct packed {
		cmd_t                command;
		logic [CH_W-1:0]     channel;
		logic [SECTOR_W-1:0] sector;
		logic [PLATE_W-1:0]  plate;
		logic [STRIP_W-1:0]  strip;
		logic [PADZ_W-1:0]   padz;
		logic [PADX_W-1:0]   padx;
	} item_t;

	typedef struct packed {
		logic [CH_W-1:0] channel;
		status_t         status;
	} enc_res_t;

	typedef struct packed {
		logic [SECTOR_W-1:0] sector;
		logic [PLATE_W-1:0]  plate;
		logic [STRIP_W-1:0]  strip;
		logic [PADZ_W-1:0]   padz;
		logic [PADX_W-1:0]   padx;
	} dec_res_t;

	function automatic logic [SIDX_W-1:0] plate_offset(input logic [PLATE_W-1:0] plate);
		logic [SIDX_W-1:0] off;
		unique case (plate)
			PLATE_0: off = '0;
			PLATE_1: off = SIDX_W'(STRIPS_C);
			PLATE_2: off = SIDX_W'(STRIPS_C + STRIPS_B);
			PLATE_3: off = SIDX_W'(STRIPS_C + STRIPS_B + STRIPS_A);
			default: off = SIDX_W'(STRIPS_C + 2 * STRIPS_B + STRIPS_A);
		endcase
		return off;
	endfunction

endpackage

[rtl/detector_channel_index_codec.sv]
`timescale 1ns / 1ps

// Channel index codec: maps detector coordinates (sector, plate, strip, pad z, pad x)
// to a flat 18-bit channel number when tuser is 0, and a channel number back to
// coordinates when tuser is 1. It takes one transaction per clock while the output is
// not stalled. The pipeline depth comes from the decode path, which splits the channel
// by a constant division and then divides its quotient and remainder in parallel,
// each division in three stages (reciprocal multiply, back-multiply and subtract,
// one correction), and ends with a final plate lookup. A stalled output holds the whole
// pipeline. Encode reports the first failing check in tuser and drives the channel
// to zero on error; pad indices are not checked. No state survives a transaction
// and no clearing pass follows reset.
module detector_channel_index_codec import dcic_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	// channel_in, sector_in, plate_in, strip_in, padz_in, padx_in, zero fill
	input  logic [DATA_W-1:0] s_axis_tdata,
	// command
	input  logic [0:0]        s_axis_tuser,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	// channel_out, sector_out, plate_out, strip_out, padz_out, padx_out, zero fill
	output logic [DATA_W-1:0] m_axis_tdata,
	// status
	output logic [STATUS_W-1:0] m_axis_tuser
);

	logic                  advance;
	logic [PIPE_DEPTH-1:0] valid_q;
	logic [PIPE_DEPTH-1:0] cmd_q;
	item_t                 item;
	enc_res_t              enc_res;
	dec_res_t              dec_res;
	logic                  is_enc;

	assign advance       = ~valid_q[PIPE_DEPTH-1] | m_axis_tready;
	assign s_axis_tready = advance;
	assign m_axis_tvalid = valid_q[PIPE_DEPTH-1];

	assign item.command = cmd_t'(s_axis_tuser[0]);
	assign item.channel = s_axis_tdata[CH_LSB +: CH_W];
	assign item.sector  = s_axis_tdata[SECTOR_LSB +: SECTOR_W];
	assign item.plate   = s_axis_tdata[PLATE_LSB +: PLATE_W];
	assign item.strip   = s_axis_tdata[STRIP_LSB +: STRIP_W];
	assign item.padz    = s_axis_tdata[PADZ_LSB +: PADZ_W];
	assign item.padx    = s_axis_tdata[PADX_LSB +: PADX_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (advance) begin
			valid_q <= {valid_q[PIPE_DEPTH-2:0], s_axis_tvalid};
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cmd_q <= {cmd_q[PIPE_DEPTH-2:0], item.command};
		end
	end

	dcic_encode u_encode (
		.clk  (clk),
		.en   (advance),
		.item (item),
		.res  (enc_res)
	);

	dcic_decode u_decode (
		.clk     (clk),
		.en      (advance),
		.channel (item.channel),
		.res     (dec_res)
	);

	assign is_enc = (cmd_t'(cmd_q[PIPE_DEPTH-1]) == CMD_ENCODE);

	assign m_axis_tdata = is_enc ?
		DATA_W'(enc_res.channel) :
		DATA_W'({dec_res.padx, dec_res.padz, dec_res.strip, dec_res.plate, dec_res.sector,
			CH_W'(0)});
	assign m_axis_tuser = is_enc ? enc_res.status : STATUS_OK;

endmodule

[rtl/dcic_encode.sv]
`timescale 1ns / 1ps

module dcic_encode import dcic_pkg::*; (
	input  logic     clk,
	input  logic     en,
	input  item_t    item,
	output enc_res_t res
);

	localparam int unsigned DLY = PIPE_DEPTH - 2;

	status_t               status_s1;
	logic [CH_W-1:0]       base_s1;
	logic [STRIDX_W-1:0]   stridx_s1;
	logic [PADIDX_W-1:0]   padidx_s1;
	enc_res_t              res_s2;
	enc_res_t              dly_q [DLY];
	status_t               status_c;
	logic [STRIP_W-1:0]    strip_lim;

	always_comb begin
		strip_lim = (item.plate == PLATE_2) ? STRIP_W'(STRIPS_A) : STRIP_W'(STRIPS_C);
		if (item.sector >= SECTOR_W'(SECTOR_COUNT)) begin
			status_c = STATUS_BAD_SECTOR;
		end else if (item.plate >= PLATE_W'(PLATE_COUNT)) begin
			status_c = STATUS_BAD_PLATE;
		end else if (item.strip >= strip_lim) begin
			status_c = STATUS_BAD_STRIP;
		end else begin
			status_c = STATUS_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			status_s1 <= status_c;
			base_s1   <= CH_W'(32'(item.sector) * SECTOR_SIZE);
			stridx_s1 <= STRIDX_W'(plate_offset(item.plate)) + STRIDX_W'(item.strip);
			padidx_s1 <= PADIDX_W'(item.padz) * PADIDX_W'(PADS_X) + PADIDX_W'(item.padx);

			res_s2.status  <= status_s1;
			res_s2.channel <= (status_s1 != STATUS_OK) ? '0 :
				CH_W'(32'(base_s1) + 32'(stridx_s1) * PADS_PER_STRIP + 32'(padidx_s1));

			dly_q[0] <= res_s2;
			for (int i = 1; i < DLY; i++) begin
				dly_q[i] <= dly_q[i-1];
			end
		end
	end

	assign res = dly_q[DLY-1];

endmodule

[rtl/dcic_decode.sv]
`timescale 1ns / 1ps

module dcic_decode import dcic_pkg::*; (
	input  logic            clk,
	input  logic            en,
	input  logic [CH_W-1:0] channel,
	output dec_res_t        res
);

	logic [MUL_W-1:0]    prod_a;
	logic [MUL_W-1:0]    prod_b;
	logic [MUL_W-1:0]    prod_c;

	logic [CH_W-1:0]     ch_s1;
	logic [CH_W-1:0]     qa_s1;
	logic [CH_W-1:0]     qa_s2;
	logic [CH_W-1:0]     ra_s2;
	logic [CH_W-1:0]     gstrip_s3;
	logic [PAD_W-1:0]    pad_s3;
	logic [CH_W-1:0]     gstrip_s4;
	logic [CH_W-1:0]     qb_s4;
	logic [PAD_W-1:0]    pad_s4;
	logic [PAD_W-1:0]    qc_s4;
	logic [SIDX_W:0]     rb_s5;
	logic [SECTOR_W-1:0] qb_s5;
	logic [PADX_W:0]     rc_s5;
	logic                qc_s5;
	logic [SECTOR_W-1:0] sec_s6;
	logic [SIDX_W-1:0]   sidx_s6;
	logic                pz_s6;
	logic [PADX_W-1:0]   px_s6;
	dec_res_t            res_s7;
	logic [PLATE_W-1:0]  plate_c;

	assign prod_a = MUL_W'(channel) * MUL_W'(RECIP_PPS);
	assign prod_b = MUL_W'(gstrip_s3) * MUL_W'(RECIP_SPS);
	assign prod_c = MUL_W'(pad_s3) * MUL_W'(RECIP_PX);

	always_comb begin
		if (sidx_s6 < plate_offset(PLATE_1)) begin
			plate_c = PLATE_0;
		end else if (sidx_s6 < plate_offset(PLATE_2)) begin
			plate_c = PLATE_1;
		end else if (sidx_s6 < plate_offset(PLATE_3)) begin
			plate_c = PLATE_2;
		end else if (sidx_s6 < plate_offset(PLATE_4)) begin
			plate_c = PLATE_3;
		end else begin
			plate_c = PLATE_4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ch_s1 <= channel;
			qa_s1 <= prod_a[RECIP_SHIFT +: CH_W];

			qa_s2 <= qa_s1;
			ra_s2 <= ch_s1 - qa_s1 * CH_W'(PADS_PER_STRIP);

			if (ra_s2 >= CH_W'(PADS_PER_STRIP)) begin
				gstrip_s3 <= qa_s2 + CH_W'(1);
				pad_s3    <= PAD_W'(ra_s2 - CH_W'(PADS_PER_STRIP));
			end else begin
				gstrip_s3 <= qa_s2;
				pad_s3    <= PAD_W'(ra_s2);
			end

			gstrip_s4 <= gstrip_s3;
			qb_s4     <= prod_b[RECIP_SHIFT +: CH_W];
			pad_s4    <= pad_s3;
			qc_s4     <= PAD_W'(prod_c[RECIP_SHIFT +: CH_W]);

			rb_s5 <= (SIDX_W + 1)'(gstrip_s4 - qb_s4 * CH_W'(STRIPS_PER_SECTOR));
			qb_s5 <= qb_s4[SECTOR_W-1:0];
			rc_s5 <= (PADX_W + 1)'(pad_s4 - qc_s4 * PAD_W'(PADS_X));
			qc_s5 <= qc_s4[0];

			if (rb_s5 >= (SIDX_W + 1)'(STRIPS_PER_SECTOR)) begin
				sec_s6  <= qb_s5 + SECTOR_W'(1);
				sidx_s6 <= SIDX_W'(rb_s5 - (SIDX_W + 1)'(STRIPS_PER_SECTOR));
			end else begin
				sec_s6  <= qb_s5;
				sidx_s6 <= SIDX_W'(rb_s5);
			end
			if (rc_s5 >= (PADX_W + 1)'(PADS_X)) begin
				pz_s6 <= ~qc_s5;
				px_s6 <= PADX_W'(rc_s5 - (PADX_W + 1)'(PADS_X));
			end else begin
				pz_s6 <= qc_s5;
				px_s6 <= PADX_W'(rc_s5);
			end

			res_s7.sector <= sec_s6;
			res_s7.plate  <= plate_c;
			res_s7.strip  <= STRIP_W'(sidx_s6 - plate_offset(plate_c));
			res_s7.padz   <= pz_s6;
			res_s7.padx   <= px_s6;
		end
	end

	assign res = res_s7;

endmodule

[rtl/dcic_checker.sv]
`timescale 1ns / 1ps

module dcic_checker import dcic_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                s_axis_tvalid,
	input logic                s_axis_tready,
	input logic [DATA_W-1:0]   s_axis_tdata,
	input logic [0:0]          s_axis_tuser,
	input logic                m_axis_tvalid,
	input logic                m_axis_tready,
	input logic [DATA_W-1:0]   m_axis_tdata,
	input logic [STATUS_W-1:0] m_axis_tuser
);

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("output transaction changed while stalled");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input refused while output stage is empty");

	a_error_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != STATUS_OK) |-> (m_axis_tdata == '0))
		else $error("error result carries non-zero data");

	a_plate_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[PLATE_LSB +: PLATE_W] < PLATE_W'(PLATE_COUNT)))
		else $error("decoded plate out of range");

endmodule

bind detector_channel_index_codec dcic_checker u_checker (.*);

[tb/sv/tb_detector_channel_index_codec.sv]
`timescale 1ns / 1ps

module tb_detector_channel_index_codec;
	import dcic_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 1000000;
	localparam int unsigned PHASES        = 8;
	localparam int unsigned PHASE_ITEMS   = 232;
	localparam int unsigned DIRECTED_ROWS = 23;
	localparam int unsigned REPORT_MAX    = 10;

	typedef struct packed {
		logic [CH_W-1:0]     channel;
		logic [SECTOR_W-1:0] sector;
		logic [PLATE_W-1:0]  plate;
		logic [STRIP_W-1:0]  strip;
		logic [PADZ_W-1:0]   padz;
		logic [PADX_W-1:0]   padx;
		status_t             status;
	} map_t;

	typedef struct {
		item_t stim;
		bit    fixed;
		map_t  want;
	} dir_row_t;

	localparam map_t NO_MAP = '0;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [DATA_W-1:0]   s_axis_tdata = '0;
	logic [0:0]          s_axis_tuser = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [DATA_W-1:0]   m_axis_tdata;
	logic [STATUS_W-1:0] m_axis_tuser;

	bit          send_fixed = 1'b0;
	map_t        send_want = '0;
	bit          idle_on = 1'b1;
	int unsigned stall_left = 0;
	int unsigned cycles = 0;
	int unsigned mismatches = 0;
	map_t        translations_due [$];
	dir_row_t    directed_rows [DIRECTED_ROWS];

	detector_channel_index_codec dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #1 clk = ~clk;

	function automatic int unsigned strips_in_plate(input logic [PLATE_W-1:0] plate);
		if (plate == PLATE_2)
			return STRIPS_A;
		if (plate == PLATE_1 || plate == PLATE_3)
			return STRIPS_B;
		return STRIPS_C;
	endfunction

	function automatic map_t translate_item(input item_t it);
		map_t                res;
		int unsigned         idx;
		int unsigned         rem;
		int unsigned         strip_no;
		int unsigned         pad;
		logic [PLATE_W-1:0]  pl;
		res = NO_MAP;
		res.status = STATUS_OK;
		if (it.command == CMD_ENCODE) begin
			if (it.sector >= SECTOR_COUNT)
				res.status = STATUS_BAD_SECTOR;
			else if (it.plate >= PLATE_COUNT)
				res.status = STATUS_BAD_PLATE;
			else if (it.strip >= ((it.plate == PLATE_2) ? STRIPS_A : STRIPS_C))
				res.status = STATUS_BAD_STRIP;
			if (res.status == STATUS_OK) begin
				strip_no = it.strip;
				for (pl = PLATE_0; pl < it.plate; pl++)
					strip_no += strips_in_plate(pl);
				idx = SECTOR_SIZE * it.sector + strip_no * PADS_PER_STRIP
					+ PADS_X * it.padz + it.padx;
				res.channel = CH_W'(idx);
			end
		end else begin
			res.sector = SECTOR_W'(it.channel / SECTOR_SIZE);
			rem = it.channel % SECTOR_SIZE;
			strip_no = rem / PADS_PER_STRIP;
			pad = rem % PADS_PER_STRIP;
			pl = PLATE_0;
			while (pl != PLATE_4 && strip_no >= strips_in_plate(pl)) begin
				strip_no -= strips_in_plate(pl);
				pl++;
			end
			res.plate = pl;
			res.strip = STRIP_W'(strip_no);
			res.padz = PADZ_W'(pad / PADS_X);
			res.padx = PADX_W'(pad % PADS_X);
		end
		return res;
	endfunction

	function automatic int unsigned idle_len();
		int unsigned r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic item_t random_item();
		item_t       it;
		int unsigned r;
		it.command = CMD_ENCODE;
		it.channel = CH_W'($urandom);
		it.sector = SECTOR_W'($urandom);
		it.plate = PLATE_W'($urandom);
		it.strip = STRIP_W'($urandom);
		it.padz = PADZ_W'($urandom);
		it.padx = PADX_W'($urandom);
		r = $urandom_range(0, 99);
		if (r < 45) begin
			it.sector = SECTOR_W'($urandom_range(0, SECTOR_COUNT - 1));
			it.plate = PLATE_W'($urandom_range(0, PLATE_COUNT - 1));
			it.strip = STRIP_W'($urandom_range(0, strips_in_plate(it.plate) - 1));
			if ($urandom_range(0, 7) != 0)
				it.padx = PADX_W'($urandom_range(0, PADS_X - 1));
		end else if (r >= 60) begin
			it.command = CMD_DECODE;
			if (r < 85)
				it.channel = CH_W'($urandom_range(0, SECTOR_COUNT * SECTOR_SIZE - 1));
		end
		return it;
	endfunction

	task automatic send_item(input item_t it, input bit fixed, input map_t want);
		int unsigned gap;
		gap = idle_len();
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= it.command;
		s_axis_tdata <= DATA_W'({it.padx, it.padz, it.strip, it.plate, it.sector, it.channel});
		send_fixed <= fixed;
		send_want <= want;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (translations_due.size() != 0);
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			stall_left <= idle_len();
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		map_t  got;
		map_t  want;
		item_t seen;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.channel = m_axis_tdata[CH_LSB +: CH_W];
				got.sector = m_axis_tdata[SECTOR_LSB +: SECTOR_W];
				got.plate = m_axis_tdata[PLATE_LSB +: PLATE_W];
				got.strip = m_axis_tdata[STRIP_LSB +: STRIP_W];
				got.padz = m_axis_tdata[PADZ_LSB +: PADZ_W];
				got.padx = m_axis_tdata[PADX_LSB +: PADX_W];
				got.status = status_t'(m_axis_tuser);
				if (translations_due.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("unexpected transaction at cycle %0d: %p", cycles, got);
				end else begin
					want = translations_due.pop_front();
					if (got.channel !== want.channel || got.sector !== want.sector ||
							got.plate !== want.plate || got.strip !== want.strip ||
							got.padz !== want.padz || got.padx !== want.padx ||
							got.status !== want.status) begin
						mismatches++;
						if (mismatches <= REPORT_MAX)
							$display("mismatch at cycle %0d: expected %p, got %p",
								cycles, want, got);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				seen.command = cmd_t'(s_axis_tuser[0]);
				seen.channel = s_axis_tdata[CH_LSB +: CH_W];
				seen.sector = s_axis_tdata[SECTOR_LSB +: SECTOR_W];
				seen.plate = s_axis_tdata[PLATE_LSB +: PLATE_W];
				seen.strip = s_axis_tdata[STRIP_LSB +: STRIP_W];
				seen.padz = s_axis_tdata[PADZ_LSB +: PADZ_W];
				seen.padx = s_axis_tdata[PADX_LSB +: PADX_W];
				translations_due.push_back(send_fixed ? send_want : translate_item(seen));
			end
		end
	end

	initial begin
		directed_rows = '{
			'{'{CMD_ENCODE, 18'd0, 5'd0, 3'd0, 5'd0, 1'd0, 6'd0}, 1'b1,
				'{18'd0, 5'd0, 3'd0, 5'd0, 1'd0, 6'd0, STATUS_OK}},
			'{'{CMD_ENCODE, 18'h3FFFF, 5'd17, 3'd4, 5'd18, 1'd1, 6'd47}, 1'b0, NO_MAP},
			'{'{CMD_ENCODE, 18'd0, 5'd17, 3'd2, 5'd14, 1'd1, 6'd63}, 1'b0, NO_MAP},
			'{'{CMD_ENCODE, 18'd0, 5'd18, 3'd0, 5'd0, 1'd0, 6'd0}, 1'b1,
				'{18'd0, 5'd0, 3'd0, 5'd0, 1'd0, 6'd0, STATUS_BAD_SECTOR}},
			'{'{CMD_ENCODE, 18'h3FFFF, 5'd31, 3'd7, 5'd31, 1'd1, 6'd63}, 1'b1,
				'{18'd0, 5'd0, 3'd0, 5'd0, 1'd0, 6'd0, STATUS_BAD_SECTOR}},
			'{'{CMD_ENCODE, 18'd0, 5'd0, 3'd5, 5'd0, 1'd0, 6'd0}, 1'b1,
				'{18'd0, 5'd0, 3'd0, 5'd0, 1'd0, 6'd0, STATUS_BAD_PLATE}},
			'{'{CMD_ENCODE, 18'd0, 5'd17, 3'd7, 5'd31, 1'd0, 6'd0}, 1'b1,
				'{18'd0, 5'd0, 3'd0, 5'd0, 1'd0, 6'd0, STATUS_BAD_PLATE}},
			'{'{CMD_ENCODE, 18'd0, 5'd3, 3'd2, 5'd15, 1'd0, 6'd5}, 1'b1,
				'{18'd0, 5'd0, 3'd0, 5'd0, 1'd0, 6'd0, STATUS_BAD_STRIP}},
			'{'{CMD_ENCODE, 18'd0, 5'd0, 3'd0, 5'd19, 1'd1, 6'd1}, 1'b1,
				'{18'd0, 5'd0, 3'd0, 5'd0, 1'd0, 6'd0, STATUS_BAD_STRIP}},
			'{'{CMD_ENCODE, 18'd0, 5'd9, 3'd4, 5'd31, 1'd0, 6'd0}, 1'b1,
				'{18'd0, 5'd0, 3'd0, 5'd0, 1'd0, 6'd0, STATUS_BAD_STRIP}},
			'{'{CMD_ENCODE, 18'd0, 5'd1, 3'd1, 5'd18, 1'd0, 6'd47}, 1'b0, NO_MAP},
			'{'{CMD_ENCODE, 18'd0, 5'd16, 3'd3, 5'd18, 1'd1, 6'd0}, 1'b0, NO_MAP},
			'{'{CMD_DECODE, 18'd0, 5'd31, 3'd7, 5'd31, 1'd1, 6'd63}, 1'b1,
				'{18'd0, 5'd0, 3'd0, 5'd0, 1'd0, 6'd0, STATUS_OK}},
			'{'{CMD_DECODE, 18'd48, 5'd0, 3'd0, 5'd0, 1'd0, 6'd0}, 1'b1,
				'{18'd0, 5'd0, 3'd0, 5'd0, 1'd1, 6'd0, STATUS_OK}},
			'{'{CMD_DECODE, 18'd96, 5'd0, 3'd0, 5'd0, 1'd0, 6'd0}, 1'b1,
				'{18'd0, 5'd0, 3'd0, 5'd1, 1'd0, 6'd0, STATUS_OK}},
			'{'{CMD_DECODE, 18'd8736, 5'd0, 3'd0, 5'd0, 1'd0, 6'd0}, 1'b1,
				'{18'd0, 5'd1, 3'd0, 5'd0, 1'd0, 6'd0, STATUS_OK}},
			'{'{CMD_DECODE, 18'h3FFFF, 5'd0, 3'd0, 5'd0, 1'd0, 6'd0}, 1'b0, NO_MAP},
			'{'{CMD_DECODE, 18'd157247, 5'd0, 3'd0, 5'd0, 1'd0, 6'd0}, 1'b0, NO_MAP},
			'{'{CMD_DECODE, 18'd157248, 5'd0, 3'd0, 5'd0, 1'd0, 6'd0}, 1'b0, NO_MAP},
			'{'{CMD_DECODE, 18'd1824, 5'd0, 3'd0, 5'd0, 1'd0, 6'd0}, 1'b0, NO_MAP},
			'{'{CMD_DECODE, 18'd5135, 5'd0, 3'd0, 5'd0, 1'd0, 6'd0}, 1'b0, NO_MAP},
			'{'{CMD_DECODE, 18'd6912, 5'd0, 3'd0, 5'd0, 1'd0, 6'd0}, 1'b0, NO_MAP},
			'{'{CMD_DECODE, 18'd8735, 5'd0, 3'd0, 5'd0, 1'd0, 6'd0}, 1'b0, NO_MAP}
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_item(directed_rows[i].stim, directed_rows[i].fixed, directed_rows[i].want);
		drain();

		for (int unsigned phase = 0; phase < PHASES; phase++) begin
			idle_on = (phase != 2 && phase != 5);
			if (phase == 4)
				drain();
			for (int unsigned n = 0; n < PHASE_ITEMS; n++)
				send_item(random_item(), 1'b0, NO_MAP);
		end

		drain();
		repeat (4 * PIPE_DEPTH) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
